@@ rtl/fpaf_pkg.sv @@
`default_nettype none
package fpaf_pkg;

  localparam int SDEC_LIMIT = 9999;
  localparam int UBIN_LIMIT = 63999;
  localparam int HUNDRED    = 100;
  localparam int ROUND_HALF = 32;
  localparam int DIGIT_BASE = 'h30;

  // floor(2^20 / 100); the quotient it gives is low by at most one.
  localparam int RECIP100   = 10485;
  localparam int RECIP_SH   = 20;

  localparam int NUM_CHARS  = 6;
  localparam int LAST_IDX   = NUM_CHARS - 1;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_POINT = 7'h2e;
  localparam logic [6:0] CH_STAR  = 7'h2a;

  localparam logic MODE_SDEC = 1'b0;
  localparam logic MODE_UBIN = 1'b1;

  typedef logic [6:0] char_t;
  typedef logic [NUM_CHARS-1:0][6:0] text_t;

  function automatic char_t digit_char(input logic [3:0] d);
    return char_t'(DIGIT_BASE) + {3'b000, d};
  endfunction

endpackage
`default_nettype wire

@@ rtl/fixed_point_to_ascii_formatter.sv @@
`default_nettype none
// Fixed-point to ASCII formatter.
// Input channel (in_valid/in_ready): one word per value, in_value is 33 bits
// two's complement, in_color is a 16-bit color. Result channel
// (out_valid/out_ready): six words per value, one ASCII character each,
// carrying the input color; out_last_char marks the sixth.
// cfg_wr_en/cfg_wr_data write format_mode: 0 prints a signed value with
// 0.01 resolution as "sDD.DD", 1 prints an unsigned 1/64 value rounded to
// hundredths as "DDD.DD". Out-of-range values print stars.
// A value passes four register stages (scale, reciprocal multiply,
// remainder correction, digit split) and then a six-character serializer.
// A value passes from stage D into the serializer, which then offers its
// first character. The serializer emits one character per cycle while the
// receiver accepts them, and takes the following value from stage D as its
// last character is accepted; the stages keep accepting until they are full.
// Reset (synchronous, active low) empties all stages, drops any value in
// flight and sets format_mode to 0. A stalled receiver holds the current
// character and backs the pipeline up without loss.
module fixed_point_to_ascii_formatter (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr_en,
  input  wire  [0:0]         cfg_wr_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [32:0] in_value,
  input  wire  [15:0]        in_color,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [6:0]         out_character,
  output logic [15:0]        out_char_color,
  output logic               out_last_char
);

  logic mode_r;

  // Stage A: range check and scaling.
  logic        va_r;
  logic [16:0] na_r;
  logic        nega_r, ovfa_r, modea_r;
  logic [15:0] cola_r;
  logic [16:0] na_nxt;
  logic        nega_nxt, ovfa_nxt;
  logic signed [32:0] negv;
  logic [13:0] mag;
  logic [22:0] scaled;

  // Stage B: reciprocal multiply.
  logic        vb_r;
  logic [16:0] nb_r;
  logic [9:0]  qb_r;
  logic        negb_r, ovfb_r, modeb_r;
  logic [15:0] colb_r;
  logic [29:0] prod;
  logic [9:0]  qb_nxt;

  // Stage C: remainder and correction.
  logic        vc_r;
  logic [9:0]  ipc_r;
  logic [6:0]  fpc_r;
  logic        negc_r, ovfc_r, modec_r;
  logic [15:0] colc_r;
  logic [16:0] rem;
  logic        fix;
  logic [9:0]  ipc_nxt;
  logic [6:0]  fpc_nxt;

  // Stage D: digit split and text.
  logic        vd_r;
  fpaf_pkg::text_t txd_r, txd_nxt;
  logic [15:0] cold_r;
  logic [15:0] p100;
  logic [17:0] p10;
  logic [14:0] pf10;
  logic [3:0]  hund, tens, units, f1, f0;
  logic [6:0]  q10;
  fpaf_pkg::char_t sgn;

  // Serializer.
  logic        sv_r;
  fpaf_pkg::text_t txs_r;
  logic [15:0] cols_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        is_last, ser_free;
  logic        rdy_b, rdy_c, rdy_d;

  assign is_last  = (cnt_r == 3'(fpaf_pkg::LAST_IDX));
  assign ser_free = !sv_r || (out_ready && is_last);
  assign rdy_d    = !vd_r || ser_free;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign in_ready = !va_r || rdy_b;

  always_comb begin
    negv     = -in_value;
    mag      = in_value[32] ? negv[13:0] : in_value[13:0];
    scaled   = 23'(in_value[15:0]) * 23'(fpaf_pkg::HUNDRED) + 23'(fpaf_pkg::ROUND_HALF);
    nega_nxt = in_value[32];
    if (mode_r == fpaf_pkg::MODE_SDEC) begin
      na_nxt   = {3'b000, mag};
      ovfa_nxt = (in_value > $signed(33'(fpaf_pkg::SDEC_LIMIT)))
              || (in_value < -$signed(33'(fpaf_pkg::SDEC_LIMIT)));
    end else begin
      na_nxt   = scaled[22:6];
      ovfa_nxt = in_value[32] || (in_value > $signed(33'(fpaf_pkg::UBIN_LIMIT)));
    end
  end

  always_comb begin
    prod   = 30'(na_r) * 30'(fpaf_pkg::RECIP100);
    qb_nxt = prod[29:fpaf_pkg::RECIP_SH];
  end

  always_comb begin
    rem     = nb_r - 17'(qb_r) * 17'(fpaf_pkg::HUNDRED);
    fix     = (rem >= 17'(fpaf_pkg::HUNDRED));
    ipc_nxt = fix ? qb_r + 10'd1 : qb_r;
    fpc_nxt = fix ? 7'(rem - 17'(fpaf_pkg::HUNDRED)) : rem[6:0];
  end

  always_comb begin
    // Small exact reciprocals: x*41>>12 = x/100 and x*205>>11 = x/10 here.
    p100  = 16'(ipc_r) * 16'd41;
    p10   = 18'(ipc_r) * 18'd205;
    pf10  = 15'(fpc_r) * 15'd205;
    hund  = p100[15:12];
    q10   = p10[17:11];
    units = 4'(ipc_r - 10'(q10) * 10'd10);
    tens  = 4'(q10 - 7'(hund) * 7'd10);
    f1    = pf10[14:11];
    f0    = 4'(fpc_r - 7'(f1) * 7'd10);
    sgn   = negc_r ? fpaf_pkg::CH_MINUS : fpaf_pkg::CH_SPACE;

    txd_nxt[3] = fpaf_pkg::CH_POINT;
    txd_nxt[4] = fpaf_pkg::digit_char(f1);
    txd_nxt[5] = fpaf_pkg::digit_char(f0);
    txd_nxt[2] = fpaf_pkg::digit_char(units);
    if (modec_r == fpaf_pkg::MODE_SDEC) begin
      if (ipc_r < 10'd10) begin
        txd_nxt[0] = fpaf_pkg::CH_SPACE;
        txd_nxt[1] = sgn;
      end else begin
        txd_nxt[0] = sgn;
        txd_nxt[1] = fpaf_pkg::digit_char(tens);
      end
    end else begin
      txd_nxt[0] = (ipc_r >= 10'd100) ? fpaf_pkg::digit_char(hund) : fpaf_pkg::CH_SPACE;
      txd_nxt[1] = (ipc_r >= 10'd10) ? fpaf_pkg::digit_char(tens) : fpaf_pkg::CH_SPACE;
    end

    if (ovfc_r) begin
      txd_nxt[0] = (modec_r == fpaf_pkg::MODE_UBIN) ? fpaf_pkg::CH_STAR : sgn;
      txd_nxt[1] = fpaf_pkg::CH_STAR;
      txd_nxt[2] = fpaf_pkg::CH_STAR;
      txd_nxt[4] = fpaf_pkg::CH_STAR;
      txd_nxt[5] = fpaf_pkg::CH_STAR;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ser_free) begin
      cnt_nxt = 3'd0;
    end else if (out_ready) begin
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      vd_r   <= 1'b0;
      sv_r   <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data[0];
      end
      if (in_ready) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_d) begin
        vd_r <= vc_r;
      end
      if (ser_free) begin
        sv_r <= vd_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      na_r    <= na_nxt;
      nega_r  <= nega_nxt;
      ovfa_r  <= ovfa_nxt;
      modea_r <= mode_r;
      cola_r  <= in_color;
    end
    if (rdy_b) begin
      nb_r    <= na_r;
      qb_r    <= qb_nxt;
      negb_r  <= nega_r;
      ovfb_r  <= ovfa_r;
      modeb_r <= modea_r;
      colb_r  <= cola_r;
    end
    if (rdy_c) begin
      ipc_r   <= ipc_nxt;
      fpc_r   <= fpc_nxt;
      negc_r  <= negb_r;
      ovfc_r  <= ovfb_r;
      modec_r <= modeb_r;
      colc_r  <= colb_r;
    end
    if (rdy_d) begin
      txd_r  <= txd_nxt;
      cold_r <= colc_r;
    end
    if (ser_free) begin
      txs_r  <= txd_r;
      cols_r <= cold_r;
    end
  end

  assign out_valid      = sv_r;
  assign out_character  = txs_r[cnt_r];
  assign out_char_color = cols_r;
  assign out_last_char  = is_last;

endmodule
`default_nettype wire
